@@ hw/rtl/hoidp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hoidp_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned STOP_W      = 16;
  localparam int unsigned SITE_W      = 16;
  localparam int unsigned EXEC_W      = 24;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 80;

  // Site field sits in bits 63:48, executor field in bits 47:24.
  localparam int unsigned SITE_LSB = 48;
  localparam int unsigned EXEC_LSB = 24;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SITE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EXEC = 1'd1;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_UC_X  = 8'h58;
  localparam logic [3:0]        LETTER_ADJ = 4'h9;

  function automatic logic is_hex_char(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
           ((c >= CHAR_LC_A) && (c <= CHAR_LC_F)) ||
           ((c >= CHAR_UC_A) && (c <= CHAR_UC_F));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
    logic [3:0] nib;
    nib = (c <= CHAR_NINE) ? c[3:0] : c[3:0] + LETTER_ADJ;
    return nib;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hex_object_id_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Hex object identifier parser.
// in_*  : one string byte per beat; in_tdata carries the byte, in_tuser flags
//         the first byte of a string. A flagged byte drops any parse underway.
// out_* : one beat per finished string: 64-bit identifier (after site and
//         executor fill/check) and the offset of the first byte not consumed.
// cfg_* : write site (index 0) and executor (index 1); zero disables each.
//         Write only while no string is in flight.
// Throughput: one byte per cycle, limited only by the single output register.
// Latency: the result beat is valid the cycle after the byte that ends the
//         string (zero byte, non-hex byte after a digit, or the last allowed digit).
// Bytes after the end are dropped without a result until the next flagged byte.
// Stall: while out_tvalid is held by a low out_tready, in_tready drops; it
//         follows out_tready in the same cycle, so a taken result frees the
//         register for the next byte without a bubble.
// Reset (synchronous, rst_n low): output empty, parser idle waiting for a
//         flagged byte, both settings cleared.
module hex_object_id_parser
  import hoidp_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = 16,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_code
  input  wire logic                   in_tuser,   // [0] first_of_string
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] id_value, [79:64] stop_offset
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned DC_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned EXT_W = (OFFSET_BITS > STOP_W) ? OFFSET_BITS : STOP_W;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [DC_W-1:0]        DC_LIMIT   = DC_W'(MAX_DIGITS);

  typedef enum logic [1:0] {
    PH_DONE,
    PH_SKIP,
    PH_DIGITS,
    PH_AFTER_ZERO
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [VALUE_W-1:0]       acc_r, acc_nxt;
  logic [DC_W-1:0]          dc_r, dc_nxt;
  logic [OFFSET_BITS-1:0]   pos_r, pos_nxt;
  logic [SITE_W-1:0]        site_r;
  logic [EXEC_W-1:0]        exec_r;
  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  logic                     accept;
  logic [CHAR_W-1:0]        ch;
  logic                     ch_hex;
  logic [3:0]               nib;
  phase_t                   cur_phase;
  logic [VALUE_W-1:0]       cur_acc;
  logic [DC_W-1:0]          cur_dc;
  logic [OFFSET_BITS-1:0]   cur_pos;
  logic [OFFSET_BITS:0]     pos_inc;
  logic [OFFSET_BITS-1:0]   pos_sat;
  logic [DC_W-1:0]          dc_inc;
  logic                     fin;
  logic [OFFSET_BITS-1:0]   fin_off;
  logic [EXT_W-1:0]         fin_off_ext;
  logic [VALUE_W-1:0]       id_site, id_final;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ch     = in_tdata[CHAR_W-1:0];
  assign ch_hex = is_hex_char(ch);
  assign nib    = hex_nibble(ch);

  // A flagged byte starts from a clean skip state.
  assign cur_phase = in_tuser ? PH_SKIP : phase_r;
  assign cur_acc   = in_tuser ? '0 : acc_r;
  assign cur_dc    = in_tuser ? '0 : dc_r;
  assign cur_pos   = in_tuser ? '0 : pos_r;

  assign pos_inc = {1'b0, cur_pos} + {{OFFSET_BITS{1'b0}}, 1'b1};
  assign pos_sat = pos_inc[OFFSET_BITS] ? OFFSET_MAX : pos_inc[OFFSET_BITS-1:0];
  assign dc_inc  = cur_dc + {{(DC_W-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt = cur_phase;
    acc_nxt   = cur_acc;
    dc_nxt    = cur_dc;
    fin       = 1'b0;
    fin_off   = cur_pos;
    unique case (cur_phase)
      PH_DONE: begin
      end
      PH_SKIP, PH_AFTER_ZERO, PH_DIGITS: begin
        if (cur_phase == PH_SKIP && in_tuser && ch == CHAR_ZERO) begin
          // Could be a digit or a prefix; decide on the next byte.
          dc_nxt    = {{(DC_W-1){1'b0}}, 1'b1};
          phase_nxt = PH_AFTER_ZERO;
        end else if (cur_phase == PH_SKIP && ch == CHAR_NUL) begin
          fin = 1'b1;
        end else if (cur_phase == PH_SKIP && !ch_hex) begin
          phase_nxt = PH_SKIP;
        end else if (cur_phase == PH_AFTER_ZERO &&
                     (ch == CHAR_LC_X || ch == CHAR_UC_X)) begin
          acc_nxt   = '0;
          dc_nxt    = '0;
          phase_nxt = PH_DIGITS;
        end else if (cur_dc >= DC_LIMIT || !ch_hex) begin
          fin = 1'b1;
        end else begin
          acc_nxt   = {cur_acc[VALUE_W-5:0], nib};
          dc_nxt    = dc_inc;
          phase_nxt = PH_DIGITS;
          if (dc_inc >= DC_LIMIT) begin
            fin     = 1'b1;
            fin_off = pos_sat;
          end
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      phase_nxt = PH_DONE;
    end
    pos_nxt = (phase_nxt != PH_DONE) ? pos_sat : cur_pos;
  end

  // Site check first, then executor on the possibly modified value.
  always_comb begin
    id_site = acc_nxt;
    if (site_r != '0) begin
      if (acc_nxt[SITE_LSB +: SITE_W] == '0) begin
        id_site[SITE_LSB +: SITE_W] = site_r;
      end else if (acc_nxt[SITE_LSB +: SITE_W] != site_r) begin
        id_site = '0;
      end
    end
    id_final = id_site;
    if (exec_r != '0) begin
      if (id_site[EXEC_LSB +: EXEC_W] == '0) begin
        id_final[EXEC_LSB +: EXEC_W] = exec_r;
      end else if (id_site[EXEC_LSB +: EXEC_W] != exec_r) begin
        id_final = '0;
      end
    end
  end

  assign fin_off_ext = EXT_W'(fin_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DONE;
      acc_r       <= '0;
      dc_r        <= '0;
      pos_r       <= '0;
      site_r      <= '0;
      exec_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SITE: site_r <= cfg_wdata[SITE_W-1:0];
          REG_EXEC: exec_r <= cfg_wdata[EXEC_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        dc_r    <= dc_nxt;
        pos_r   <= pos_nxt;
        if (fin) begin
          out_valid_r <= 1'b1;
          out_data_r  <= {fin_off_ext[STOP_W-1:0], id_final};
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hoidp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hoidp_checker
  import hoidp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // Output register empties on reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // An empty output register never blocks input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with empty output");

  // A new result beat comes only from a byte taken the cycle before.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid && !out_tready) |-> $past(in_tvalid && in_tready))
    else $error("result beat without an accepted byte");

  // A string that opens with its terminator ends at offset zero.
  a_empty_string: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && in_tdata == CHAR_NUL |=>
      out_tvalid && out_tdata[OUT_TDATA_W-1:VALUE_W] == '0)
    else $error("empty string result wrong");

endmodule

bind hex_object_id_parser hoidp_checker u_hoidp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
